// ===== src/elev_disp_pkg.sv =====
package elev_disp_pkg;

    localparam int ENTRIES   = 16;
    localparam int FLOORS    = 64;
    localparam int IDX_W     = $clog2(ENTRIES);
    localparam int CNT_W     = $clog2(ENTRIES + 1);
    localparam int FLOOR_W   = 6;
    localparam int CAP_W     = 4;
    localparam int TIME_W    = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 6;

    localparam logic [FLOOR_W-1:0] FLOOR_TOP = FLOOR_W'(FLOORS - 1);
    localparam logic [CAP_W-1:0]   CAPACITY_RESET = CAP_W'(4);

    localparam logic [CFG_IDX_W-1:0] REG_CAPACITY    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_START_FLOOR = CFG_IDX_W'(1);

    typedef logic signed [1:0] dir_t;
    localparam dir_t DIR_UP   = 2'sd1;
    localparam dir_t DIR_STOP = 2'sd0;
    localparam dir_t DIR_DOWN = -2'sd1;

    // One waiting or riding passenger.
    typedef struct packed {
        logic               riding;
        logic [FLOOR_W-1:0] floor;
        logic [FLOOR_W-1:0] target;
    } entry_t;

    // Access to the entry table for one cycle.
    typedef struct packed {
        logic             insert;
        logic             wr_en;
        logic [IDX_W-1:0] wr_idx;
        logic [IDX_W-1:0] rd_idx;
    } tbl_ctrl_t;

endpackage

// ===== src/elev_disp_table.sv =====
module elev_disp_table
    import elev_disp_pkg::*;
(
    input  logic      aclk,
    input  tbl_ctrl_t ctrl,
    input  entry_t    ins_entry,
    input  entry_t    wr_entry,
    output entry_t    rd_entry
);

    // Entries are kept newest first: position 0 holds the latest request.
    entry_t ent_reg [ENTRIES];

    always_ff @(posedge aclk) begin
        if (ctrl.insert) begin
            ent_reg[0] <= ins_entry;
            for (int i = 1; i < ENTRIES; i++) begin
                ent_reg[i] <= ent_reg[i-1];
            end
        end else if (ctrl.wr_en) begin
            ent_reg[ctrl.wr_idx] <= wr_entry;
        end
    end

    assign rd_entry = ent_reg[ctrl.rd_idx];

endmodule

// ===== src/elevator_dispatch_step.sv =====
// Single-car elevator controller. A request beat (mode 0) stores a passenger in a
// 16-entry table kept newest first, or is refused with accepted low when the table
// is full; its result is registered and the input is ready again once the result
// beat is taken. A tick beat (mode 1) moves the car one floor, advances the time,
// and then walks the stored entries one per cycle through a single compare and
// update path: boarding, alighting, compacting the table and tracking the lowest
// and highest outstanding floor all happen in that walk, which covers the 0 to 16
// stored entries; the direction is then set in ST_DIR and the result registered.
// The input is not ready while an item is in work or its result is pending.
// Writing start_floor also moves the car there at once; writes are taken any time
// but are meant for an idle block.
module elevator_dispatch_step
    import elev_disp_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data,

    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_mode,
    input  logic [FLOOR_W-1:0]   s_from_floor,
    input  logic [FLOOR_W-1:0]   s_to_floor,

    output logic                 m_valid,
    input  logic                 m_ready,
    output logic                 m_accepted,
    output logic [FLOOR_W-1:0]   m_car_floor_now,
    output logic [TIME_W-1:0]    m_time_now,
    output logic [CAP_W-1:0]     m_riders_now,
    output logic signed [1:0]    m_direction_now,
    output logic                 m_changed
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_DIR,
        ST_OUT
    } state_t;

    function automatic logic [FLOOR_W-1:0] clamp_floor(input logic [FLOOR_W-1:0] f);
        return (f > FLOOR_TOP) ? FLOOR_TOP : f;
    endfunction

    state_t             state_reg;
    logic [CAP_W-1:0]   capacity_reg;
    logic [FLOOR_W-1:0] car_floor_reg;
    dir_t               car_dir_reg;
    logic [CAP_W-1:0]   rider_reg;
    logic [TIME_W-1:0]  tick_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [IDX_W-1:0]   k_reg;
    logic [CNT_W-1:0]   w_reg;
    logic [FLOOR_W-1:0] lo_reg;
    logic [FLOOR_W-1:0] hi_reg;
    logic               changed_reg;

    logic               m_valid_reg;
    logic               m_accepted_reg;
    logic               m_changed_reg;

    tbl_ctrl_t          tbl_ctrl;
    entry_t             ins_entry;
    entry_t             rd_entry;
    entry_t             upd_entry;

    logic               s_beat;
    logic               cfg_beat;
    logic               board;
    logic               alight;
    logic               last;
    logic [FLOOR_W-1:0] out_floor;
    logic [CNT_W-1:0]   w_next;
    logic [CAP_W-1:0]   rider_next;
    logic [FLOOR_W-1:0] floor_moved;
    dir_t               dir_next;

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign s_beat    = s_valid && s_ready;
    assign cfg_beat  = cfg_valid && cfg_ready;

    // Walk step: one entry per cycle, newest first.
    always_comb begin
        upd_entry = rd_entry;
        board  = !rd_entry.riding && (rd_entry.floor == car_floor_reg)
                 && (rider_reg < capacity_reg);
        alight = rd_entry.riding && (rd_entry.target == car_floor_reg);
        if (board) begin
            upd_entry.riding = 1'b1;
        end
        out_floor  = upd_entry.riding ? upd_entry.target : upd_entry.floor;
        w_next     = alight ? w_reg : w_reg + CNT_W'(1);
        rider_next = rider_reg;
        if (board) begin
            rider_next = rider_reg + CAP_W'(1);
        end else if (alight && rider_reg != '0) begin
            rider_next = rider_reg - CAP_W'(1);
        end
        last = ({1'b0, k_reg} == cnt_reg - CNT_W'(1));
    end

    always_comb begin
        tbl_ctrl.insert = s_beat && !s_mode && (cnt_reg != CNT_W'(ENTRIES));
        tbl_ctrl.wr_en  = (state_reg == ST_WALK) && !alight;
        tbl_ctrl.wr_idx = w_reg[IDX_W-1:0];
        tbl_ctrl.rd_idx = k_reg;
        ins_entry.riding = 1'b0;
        ins_entry.floor  = clamp_floor(s_from_floor);
        ins_entry.target = clamp_floor(s_to_floor);
    end

    always_comb begin
        floor_moved = car_floor_reg;
        if (car_dir_reg == DIR_UP && car_floor_reg < FLOOR_TOP) begin
            floor_moved = car_floor_reg + FLOOR_W'(1);
        end else if (car_dir_reg == DIR_DOWN && car_floor_reg != '0) begin
            floor_moved = car_floor_reg - FLOOR_W'(1);
        end
    end

    // A car strictly between the lowest and highest floor keeps going its way; a stopped one goes up.
    always_comb begin
        if (cnt_reg == '0) begin
            dir_next = DIR_STOP;
        end else if (car_floor_reg <= lo_reg) begin
            dir_next = DIR_UP;
        end else if (car_floor_reg >= hi_reg) begin
            dir_next = DIR_DOWN;
        end else if (car_dir_reg == DIR_STOP) begin
            dir_next = DIR_UP;
        end else begin
            dir_next = car_dir_reg;
        end
    end

    elev_disp_table u_table (
        .aclk      (aclk),
        .ctrl      (tbl_ctrl),
        .ins_entry (ins_entry),
        .wr_entry  (upd_entry),
        .rd_entry  (rd_entry)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            capacity_reg   <= CAPACITY_RESET;
            car_floor_reg  <= clamp_floor('0);
            car_dir_reg    <= DIR_STOP;
            rider_reg      <= '0;
            tick_reg       <= '0;
            cnt_reg        <= '0;
            k_reg          <= '0;
            w_reg          <= '0;
            changed_reg    <= 1'b0;
            m_valid_reg    <= 1'b0;
            m_accepted_reg <= 1'b0;
            m_changed_reg  <= 1'b0;
        end else begin
            if (cfg_beat) begin
                unique case (cfg_index)
                    REG_CAPACITY: begin
                        capacity_reg <= cfg_data[CAP_W-1:0];
                    end
                    REG_START_FLOOR: begin
                        car_floor_reg <= clamp_floor(cfg_data);
                    end
                    default: begin
                    end
                endcase
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (s_beat) begin
                        if (!s_mode) begin
                            if (cnt_reg != CNT_W'(ENTRIES)) begin
                                cnt_reg        <= cnt_reg + CNT_W'(1);
                                m_accepted_reg <= 1'b1;
                            end else begin
                                m_accepted_reg <= 1'b0;
                            end
                            m_changed_reg <= 1'b0;
                            m_valid_reg   <= 1'b1;
                            state_reg     <= ST_OUT;
                        end else begin
                            tick_reg      <= tick_reg + TIME_W'(1);
                            car_floor_reg <= floor_moved;
                            k_reg         <= '0;
                            w_reg         <= '0;
                            lo_reg        <= '1;
                            hi_reg        <= '0;
                            changed_reg   <= 1'b0;
                            state_reg     <= (cnt_reg == '0) ? ST_DIR : ST_WALK;
                        end
                    end
                end
                ST_WALK: begin
                    rider_reg <= rider_next;
                    w_reg     <= w_next;
                    k_reg     <= k_reg + IDX_W'(1);
                    if (board || alight) begin
                        changed_reg <= 1'b1;
                    end
                    if (!alight) begin
                        if (out_floor < lo_reg) begin
                            lo_reg <= out_floor;
                        end
                        if (out_floor > hi_reg) begin
                            hi_reg <= out_floor;
                        end
                    end
                    if (last) begin
                        cnt_reg   <= w_next;
                        state_reg <= ST_DIR;
                    end
                end
                ST_DIR: begin
                    car_dir_reg    <= dir_next;
                    m_changed_reg  <= changed_reg || (dir_next != car_dir_reg);
                    m_accepted_reg <= 1'b1;
                    m_valid_reg    <= 1'b1;
                    state_reg      <= ST_OUT;
                end
                ST_OUT: begin
                    if (m_ready) begin
                        m_valid_reg <= 1'b0;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_accepted      = m_accepted_reg;
    assign m_car_floor_now = car_floor_reg;
    assign m_time_now      = tick_reg;
    assign m_riders_now    = rider_reg;
    assign m_direction_now = car_dir_reg;
    assign m_changed       = m_changed_reg;

endmodule

// ===== tb/sv/elevator_tb_pkg.sv =====
package elevator_tb_pkg;

    import elev_disp_pkg::*;

    localparam logic MODE_REQUEST = 1'b0;
    localparam logic MODE_TICK    = 1'b1;

    // Register indexes that the block has no register behind.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = CFG_IDX_W'(3);

endpackage

// ===== tb/sv/elevator_dispatch_checker.sv =====
module elevator_dispatch_checker
    import elev_disp_pkg::*;
    import elevator_tb_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data,

    input  logic                 s_valid,
    input  logic                 s_ready,
    input  logic                 s_mode,
    input  logic [FLOOR_W-1:0]   s_from_floor,
    input  logic [FLOOR_W-1:0]   s_to_floor,

    input  logic                 m_valid,
    input  logic                 m_ready,
    input  logic                 m_accepted,
    input  logic [FLOOR_W-1:0]   m_car_floor_now,
    input  logic [TIME_W-1:0]    m_time_now,
    input  logic [CAP_W-1:0]     m_riders_now,
    input  logic signed [1:0]    m_direction_now,
    input  logic                 m_changed,

    output int                   pending,
    output int                   error_count,
    output int                   refusals,
    output int                   busy_ticks
);

    typedef struct packed {
        logic               accepted;
        logic [FLOOR_W-1:0] car_floor;
        logic [TIME_W-1:0]  time_now;
        logic [CAP_W-1:0]   riders;
        dir_t               direction;
        logic               changed;
    } car_status_t;

    typedef logic signed [TIME_W:0] field_t;

    // Passenger table as the predictor sees it; rank 0 is the newest entry.
    logic               occupied   [ENTRIES];
    logic               aboard     [ENTRIES];
    logic [FLOOR_W-1:0] wait_floor [ENTRIES];
    logic [FLOOR_W-1:0] dest_floor [ENTRIES];
    int                 rank       [ENTRIES];

    logic [FLOOR_W-1:0] car_pos;
    dir_t               heading;
    int                 load;
    logic [TIME_W-1:0]  tick_total;
    logic [CAP_W-1:0]   cap_reg;

    car_status_t expected_status [$];
    int mismatches = 0;
    int refused = 0;
    int active = 0;

    function automatic logic [FLOOR_W-1:0] clip_floor(input logic [FLOOR_W-1:0] f);
        return (f > FLOOR_TOP) ? FLOOR_TOP : f;
    endfunction

    function automatic car_status_t snapshot(input logic ok, input logic stirred);
        car_status_t st;
        st.accepted  = ok;
        st.car_floor = car_pos;
        st.time_now  = tick_total;
        st.riders    = CAP_W'(load);
        st.direction = heading;
        st.changed   = stirred;
        return st;
    endfunction

    function automatic void reset_model();
        for (int i = 0; i < ENTRIES; i++) begin
            occupied[i] = 1'b0;
            aboard[i]   = 1'b0;
            rank[i]     = 0;
        end
        car_pos    = '0;
        heading    = DIR_STOP;
        load       = 0;
        tick_total = '0;
        cap_reg    = CAPACITY_RESET;
    endfunction

    function automatic car_status_t store_request(input logic [FLOOR_W-1:0] from_f,
                                                  input logic [FLOOR_W-1:0] to_f);
        int slot;
        slot = -1;
        for (int i = ENTRIES - 1; i >= 0; i--)
            if (!occupied[i]) slot = i;
        if (slot < 0)
            return snapshot(1'b0, 1'b0);
        for (int i = 0; i < ENTRIES; i++)
            if (occupied[i]) rank[i]++;
        occupied[slot]   = 1'b1;
        aboard[slot]     = 1'b0;
        wait_floor[slot] = clip_floor(from_f);
        dest_floor[slot] = clip_floor(to_f);
        rank[slot]       = 0;
        return snapshot(1'b1, 1'b0);
    endfunction

    function automatic car_status_t run_tick();
        int                 order [ENTRIES];
        int                 fresh [ENTRIES];
        int                 n, s;
        logic [FLOOR_W-1:0] lo, hi, f;
        logic               any, stirred;
        dir_t               next_dir;
        n = 0;
        lo = '0;
        hi = '0;
        any = 1'b0;
        stirred = 1'b0;
        tick_total = tick_total + TIME_W'(1);
        if (heading == DIR_UP && car_pos < FLOOR_TOP) car_pos = car_pos + FLOOR_W'(1);
        else if (heading == DIR_DOWN && car_pos != '0) car_pos = car_pos - FLOOR_W'(1);

        // The walk order is fixed before anyone boards or leaves.
        for (int k = 0; k < ENTRIES; k++)
            for (int i = 0; i < ENTRIES; i++)
                if (occupied[i] && rank[i] == k) begin
                    order[n] = i;
                    n++;
                end
        for (int k = 0; k < n; k++) begin
            s = order[k];
            if (!aboard[s]) begin
                if (wait_floor[s] == car_pos && CAP_W'(load) < cap_reg) begin
                    aboard[s] = 1'b1;
                    load++;
                    stirred = 1'b1;
                end
            end else if (dest_floor[s] == car_pos) begin
                occupied[s] = 1'b0;
                aboard[s]   = 1'b0;
                if (load > 0) load--;
                stirred = 1'b1;
            end
        end

        for (int i = 0; i < ENTRIES; i++) begin
            fresh[i] = 0;
            if (occupied[i])
                for (int j = 0; j < ENTRIES; j++)
                    if (occupied[j] && rank[j] < rank[i]) fresh[i]++;
        end
        rank = fresh;

        for (int i = 0; i < ENTRIES; i++) begin
            if (occupied[i]) begin
                f = aboard[i] ? dest_floor[i] : wait_floor[i];
                if (!any) begin
                    lo = f;
                    hi = f;
                    any = 1'b1;
                end else begin
                    if (f < lo) lo = f;
                    if (f > hi) hi = f;
                end
            end
        end

        // Between the lowest and highest outstanding floor the car keeps going; a stopped car goes up.
        if (!any) next_dir = DIR_STOP;
        else if (car_pos <= lo) next_dir = DIR_UP;
        else if (car_pos >= hi) next_dir = DIR_DOWN;
        else next_dir = (heading == DIR_STOP) ? DIR_UP : heading;
        if (next_dir != heading) stirred = 1'b1;
        heading = next_dir;
        return snapshot(1'b1, stirred);
    endfunction

    function automatic void check_field(input string name,
                                        input field_t want,
                                        input field_t got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge aclk) begin
        car_status_t want;
        if (!aresetn) begin
            reset_model();
            expected_status.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (expected_status.size() == 0) begin
                    $error("result beat arrived with nothing outstanding");
                    mismatches++;
                end else begin
                    want = expected_status.pop_front();
                    check_field("accepted", field_t'(want.accepted), field_t'(m_accepted));
                    check_field("car_floor_now", field_t'(want.car_floor),
                                field_t'(m_car_floor_now));
                    check_field("time_now", field_t'(want.time_now), field_t'(m_time_now));
                    check_field("riders_now", field_t'(want.riders), field_t'(m_riders_now));
                    check_field("direction_now", field_t'($signed(want.direction)),
                                field_t'(m_direction_now));
                    check_field("changed", field_t'(want.changed), field_t'(m_changed));
                end
            end
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == REG_CAPACITY) cap_reg = cfg_data[CAP_W-1:0];
                else if (cfg_index == REG_START_FLOOR) car_pos = clip_floor(cfg_data);
            end
            if (s_valid && s_ready) begin
                if (s_mode == MODE_TICK) begin
                    want = run_tick();
                    if (want.changed) active++;
                end else begin
                    want = store_request(s_from_floor, s_to_floor);
                    if (!want.accepted) refused++;
                end
                expected_status.push_back(want);
            end
        end
        pending     <= expected_status.size();
        error_count <= mismatches;
        refusals    <= refused;
        busy_ticks  <= active;
    end

endmodule

// ===== tb/sv/tb_elevator_dispatch_step.sv =====
module tb_elevator_dispatch_step;

    import elev_disp_pkg::*;
    import elevator_tb_pkg::*;

    localparam int RANDOM_ITEMS = 550;
    localparam int STALL_LIMIT  = 4000;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;

    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DAT_W-1:0] cfg_data = '0;

    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic                 s_mode = MODE_REQUEST;
    logic [FLOOR_W-1:0]   s_from_floor = '0;
    logic [FLOOR_W-1:0]   s_to_floor = '0;

    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic                 m_accepted;
    logic [FLOOR_W-1:0]   m_car_floor_now;
    logic [TIME_W-1:0]    m_time_now;
    logic [CAP_W-1:0]     m_riders_now;
    logic signed [1:0]    m_direction_now;
    logic                 m_changed;

    int pending;
    int error_count;
    int refusals;
    int busy_ticks;

    int n_requests = 0;
    int n_ticks = 0;
    int settings = 0;
    int burst_left = 0;
    int quiet_cycles = 0;
    int stall_mode = 0;
    int stall_left = 0;

    elevator_dispatch_step dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_mode          (s_mode),
        .s_from_floor    (s_from_floor),
        .s_to_floor      (s_to_floor),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_accepted      (m_accepted),
        .m_car_floor_now (m_car_floor_now),
        .m_time_now      (m_time_now),
        .m_riders_now    (m_riders_now),
        .m_direction_now (m_direction_now),
        .m_changed       (m_changed)
    );

    elevator_dispatch_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_mode          (s_mode),
        .s_from_floor    (s_from_floor),
        .s_to_floor      (s_to_floor),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_accepted      (m_accepted),
        .m_car_floor_now (m_car_floor_now),
        .m_time_now      (m_time_now),
        .m_riders_now    (m_riders_now),
        .m_direction_now (m_direction_now),
        .m_changed       (m_changed),
        .pending         (pending),
        .error_count     (error_count),
        .refusals        (refusals),
        .busy_ticks      (busy_ticks)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // The result side switches between stall patterns of random length.
    always @(posedge aclk) begin
        if (stall_left == 0) begin
            stall_mode <= $urandom_range(0, 3);
            stall_left <= $urandom_range(4, 40);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            0: m_ready <= 1'b1;
            1: m_ready <= ($urandom_range(0, 3) != 0);
            2: m_ready <= ($urandom_range(0, 1) == 1);
            default: m_ready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic logic [FLOOR_W-1:0] pick_floor(input int base);
        if ($urandom_range(0, 9) < 7)
            return FLOOR_W'(base + $urandom_range(0, 7));
        return FLOOR_W'($urandom);
    endfunction

    // Valid stays high across a burst; a gap of random length lowers it between bursts.
    task automatic send_item(input logic mode, input logic [FLOOR_W-1:0] from_f,
                             input logic [FLOOR_W-1:0] to_f);
        int gap;
        s_valid      <= 1'b1;
        s_mode       <= mode;
        s_from_floor <= from_f;
        s_to_floor   <= to_f;
        do @(posedge aclk); while (!s_ready);
        if (mode == MODE_TICK) n_ticks++;
        else n_requests++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 16);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    task automatic send_request(input int base);
        send_item(MODE_REQUEST, pick_floor(base), pick_floor(base));
    endtask

    task automatic send_tick();
        send_item(MODE_TICK, FLOOR_W'($urandom), FLOOR_W'($urandom));
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    task automatic program_regs(input logic [CFG_DAT_W-1:0] cap_data,
                                input logic [CFG_DAT_W-1:0] start_data, input bit poke_spare);
        drain();
        if (poke_spare)
            write_reg($urandom_range(0, 1) ? REG_SPARE_HI : REG_SPARE_LO, CFG_DAT_W'($urandom));
        write_reg(REG_CAPACITY, cap_data);
        write_reg(REG_START_FLOOR, start_data);
        cfg_valid <= 1'b0;
        settings++;
    endtask

    initial begin
        int goal, phase, band, phase_len, req_pct;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Car of two at floor 0: three wait there, one boards at its own
        // destination, and the oldest is left behind by a full car.
        program_regs(CFG_DAT_W'(2), CFG_DAT_W'(0), 1'b1);
        send_tick();
        send_item(MODE_REQUEST, FLOOR_W'(0), FLOOR_W'(3));
        send_item(MODE_REQUEST, FLOOR_W'(0), FLOOR_W'(0));
        send_item(MODE_REQUEST, FLOOR_W'(0), FLOOR_W'(7));
        send_item(MODE_REQUEST, FLOOR_W'(63), FLOOR_W'(63));
        repeat (4) send_tick();

        // Capacity zero through the ignored upper bit, car jumps to the top,
        // then the table is overfilled.
        program_regs(CFG_DAT_W'(6'h10), CFG_DAT_W'(6'h3F), 1'b0);
        repeat (14) send_item(MODE_REQUEST, FLOOR_W'(63), FLOOR_W'($urandom));
        repeat (2) send_tick();

        goal = n_requests + n_ticks + RANDOM_ITEMS;
        phase = 0;
        while (n_requests + n_ticks < goal) begin
            band = $urandom_range(0, FLOORS - 8);
            case (phase)
                0: begin
                    band = 0;
                    program_regs(CFG_DAT_W'(1), CFG_DAT_W'(0), 1'b0);
                end
                1: begin
                    band = FLOORS - 8;
                    program_regs(CFG_DAT_W'(15), CFG_DAT_W'(6'h3F), 1'b1);
                end
                2: program_regs(CFG_DAT_W'(6'h20), CFG_DAT_W'(band), 1'b0);
                3: program_regs(CFG_DAT_W'(6'h3F), CFG_DAT_W'(band + 3), 1'b1);
                default: program_regs({2'($urandom), 4'($urandom_range(1, 15))},
                                      CFG_DAT_W'(band + $urandom_range(0, 7)),
                                      $urandom_range(0, 1));
            endcase
            phase_len = (phase == 2) ? 25 : $urandom_range(40, 80);
            req_pct = $urandom_range(25, 55);
            for (int n = 0; n < phase_len && n_requests + n_ticks < goal; n++) begin
                if ($urandom_range(0, 99) < 4)
                    repeat ($urandom_range(6, 18)) send_request(band);
                else if ($urandom_range(0, 99) < req_pct)
                    send_request(band);
                else
                    send_tick();
            end
            phase++;
        end

        drain();
        repeat (40) @(posedge aclk);
        $display("Sent %0d requests (%0d refused by a full table) and %0d ticks, %0d of which",
                 n_requests, refusals, n_ticks, busy_ticks);
        $display("boarded, dropped off or turned the car, over %0d register settings.", settings);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
